// ===== hw/rtl/pvge_pkg.sv =====
// Package for the polyline vertex geometry engine.
// Holds op codes, datapath command codes, the status struct and rounding helpers.
// No dependencies.
package pvge_pkg;

  localparam int MaxVerticesDef   = 64;
  localparam int CoordFracBitsDef = 16;
  localparam int TrigFracBits     = 16;
  localparam int DivIters         = 32;
  localparam int SqrtIters        = 32;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_TRANSLATE = 3'd1,
    OP_SCALE     = 3'd2,
    OP_ROTATE    = 3'd3,
    OP_DISTANCE  = 3'd4,
    OP_BOX       = 3'd5
  } op_e;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_RD_I,
    CMD_RDB_CAPA,
    CMD_CAP_V,
    CMD_SC_M1,
    CMD_SC_M2,
    CMD_SC_M3,
    CMD_RT_M1,
    CMD_RT_M2,
    CMD_RT_M3,
    CMD_RT_M4,
    CMD_RT_M5,
    CMD_XF_WR,
    CMD_CAP_B,
    CMD_SETUP,
    CMD_D_M1,
    CMD_D_M2,
    CMD_D_M3,
    CMD_D_M4,
    CMD_D_M5,
    CMD_DEC,
    CMD_DIV,
    CMD_OFF1,
    CMD_OFF2,
    CMD_OFF3,
    CMD_S1,
    CMD_S2,
    CMD_S3,
    CMD_SQ_INIT,
    CMD_SQ,
    CMD_FIN
  } cmd_e;

  typedef struct packed {
    logic dot_le0;
    logic dot_ge_len;
    logic last_vtx;
    logic last_seg;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -67'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_sat(input logic signed [66:0] v,
                                                 input int unsigned s);
    logic signed [66:0] t;
    t = (v + (67'sd1 <<< (s - 1))) >>> s;
    return sat32(t);
  endfunction

endpackage

// ===== hw/rtl/pvge_ctrl.sv =====
// Sequencer of the polyline vertex geometry engine.
// Walks vertices and segments and issues one datapath command per cycle while busy, a NOP while the result waits.
// Depends on pvge_pkg.
module pvge_ctrl import pvge_pkg::*; #(
  parameter int MaxVertices = MaxVerticesDef,
  localparam int Aw = (MaxVertices > 1) ? $clog2(MaxVertices) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [2:0]    in_op_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  dp_status_t    status_i,
  output cmd_e          cmd_o,
  output logic [Aw-1:0] vidx_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_WRITE,
    S_XF_RD, S_XF_CAP, S_SC1, S_SC2, S_SC3,
    S_RT1, S_RT2, S_RT3, S_RT4, S_RT5, S_XF_WR,
    S_D_RDA, S_D_RDB, S_D_CAPB, S_D_SETUP,
    S_D_M1, S_D_M2, S_D_M3, S_D_M4, S_D_M5, S_D_DEC, S_D_DIV,
    S_D_OFF1, S_D_OFF2, S_D_OFF3, S_D_S1, S_D_S2, S_D_S3,
    S_SQ_INIT, S_SQ, S_BOX_RD, S_BOX_CAP, S_FIN
  } state_e;

  state_e        state_q;
  logic [2:0]    op_q;
  logic [Aw-1:0] i_q;
  logic [4:0]    cnt_q;
  logic          valid_q;
  logic          out_free;
  logic          in_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign vidx_o      = i_q;
  assign out_free    = !valid_q || out_ready_i;

  always_comb begin
    case (state_q)
      S_WRITE:   cmd_o = CMD_WRITE;
      S_XF_RD:   cmd_o = CMD_RD_I;
      S_XF_CAP:  cmd_o = CMD_CAP_V;
      S_SC1:     cmd_o = CMD_SC_M1;
      S_SC2:     cmd_o = CMD_SC_M2;
      S_SC3:     cmd_o = CMD_SC_M3;
      S_RT1:     cmd_o = CMD_RT_M1;
      S_RT2:     cmd_o = CMD_RT_M2;
      S_RT3:     cmd_o = CMD_RT_M3;
      S_RT4:     cmd_o = CMD_RT_M4;
      S_RT5:     cmd_o = CMD_RT_M5;
      S_XF_WR:   cmd_o = CMD_XF_WR;
      S_D_RDA:   cmd_o = CMD_RD_I;
      S_D_RDB:   cmd_o = CMD_RDB_CAPA;
      S_D_CAPB:  cmd_o = CMD_CAP_B;
      S_D_SETUP: cmd_o = CMD_SETUP;
      S_D_M1:    cmd_o = CMD_D_M1;
      S_D_M2:    cmd_o = CMD_D_M2;
      S_D_M3:    cmd_o = CMD_D_M3;
      S_D_M4:    cmd_o = CMD_D_M4;
      S_D_M5:    cmd_o = CMD_D_M5;
      S_D_DEC:   cmd_o = CMD_DEC;
      S_D_DIV:   cmd_o = CMD_DIV;
      S_D_OFF1:  cmd_o = CMD_OFF1;
      S_D_OFF2:  cmd_o = CMD_OFF2;
      S_D_OFF3:  cmd_o = CMD_OFF3;
      S_D_S1:    cmd_o = CMD_S1;
      S_D_S2:    cmd_o = CMD_S2;
      S_D_S3:    cmd_o = CMD_S3;
      S_SQ_INIT: cmd_o = CMD_SQ_INIT;
      S_SQ:      cmd_o = CMD_SQ;
      S_BOX_RD:  cmd_o = CMD_RD_I;
      S_BOX_CAP: cmd_o = CMD_CAP_V;
      S_FIN:     cmd_o = out_free ? CMD_FIN : CMD_NOP;
      default:   cmd_o = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= 3'd0;
      i_q     <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (valid_q && out_ready_i && state_q != S_FIN) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q <= in_op_i;
            i_q  <= '0;
            case (in_op_i)
              OP_WRITE:                          state_q <= S_WRITE;
              OP_TRANSLATE, OP_SCALE, OP_ROTATE: state_q <= S_XF_RD;
              OP_DISTANCE:                       state_q <= S_D_RDA;
              OP_BOX:                            state_q <= S_BOX_RD;
              default:                           state_q <= S_FIN;
            endcase
          end
        end
        S_WRITE:  state_q <= S_FIN;
        S_XF_RD:  state_q <= S_XF_CAP;
        S_XF_CAP: begin
          case (op_q)
            OP_SCALE:  state_q <= S_SC1;
            OP_ROTATE: state_q <= S_RT1;
            default:   state_q <= S_XF_WR;
          endcase
        end
        S_SC1: state_q <= S_SC2;
        S_SC2: state_q <= S_SC3;
        S_SC3: state_q <= S_XF_WR;
        S_RT1: state_q <= S_RT2;
        S_RT2: state_q <= S_RT3;
        S_RT3: state_q <= S_RT4;
        S_RT4: state_q <= S_RT5;
        S_RT5: state_q <= S_XF_WR;
        S_XF_WR: begin
          if (status_i.last_vtx) begin
            state_q <= S_FIN;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_XF_RD;
          end
        end
        S_D_RDA:   state_q <= S_D_RDB;
        S_D_RDB:   state_q <= S_D_CAPB;
        S_D_CAPB:  state_q <= S_D_SETUP;
        S_D_SETUP: state_q <= S_D_M1;
        S_D_M1:    state_q <= S_D_M2;
        S_D_M2:    state_q <= S_D_M3;
        S_D_M3:    state_q <= S_D_M4;
        S_D_M4:    state_q <= S_D_M5;
        S_D_M5:    state_q <= S_D_DEC;
        S_D_DEC: begin
          if (status_i.dot_le0 || status_i.dot_ge_len) begin
            state_q <= S_D_S1;
          end else begin
            cnt_q   <= '0;
            state_q <= S_D_DIV;
          end
        end
        S_D_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(DivIters - 1)) begin
            state_q <= S_D_OFF1;
          end
        end
        S_D_OFF1: state_q <= S_D_OFF2;
        S_D_OFF2: state_q <= S_D_OFF3;
        S_D_OFF3: state_q <= S_D_S1;
        S_D_S1:   state_q <= S_D_S2;
        S_D_S2:   state_q <= S_D_S3;
        S_D_S3: begin
          if (status_i.last_seg) begin
            state_q <= S_SQ_INIT;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_D_RDA;
          end
        end
        S_SQ_INIT: begin
          cnt_q   <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(SqrtIters - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_BOX_RD: state_q <= S_BOX_CAP;
        S_BOX_CAP: begin
          if (status_i.last_vtx) begin
            state_q <= S_FIN;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_BOX_RD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pvge_dp.sv =====
// Datapath of the polyline vertex geometry engine.
// Vertex memory, shared multiplier, restoring divider, square root, bounding-box trackers and result register.
// Depends on pvge_pkg.
module pvge_dp import pvge_pkg::*; #(
  parameter int MaxVertices   = MaxVerticesDef,
  parameter int CoordFracBits = CoordFracBitsDef,
  localparam int Aw = (MaxVertices > 1) ? $clog2(MaxVertices) : 1,
  localparam int Nw = $clog2(MaxVertices + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_fire_i,
  input  logic [2:0]         in_op_i,
  input  logic [5:0]         in_idx_i,
  input  logic signed [31:0] in_cx_i,
  input  logic signed [31:0] in_cy_i,
  input  logic signed [31:0] in_f_i,
  input  logic signed [17:0] in_c_i,
  input  logic signed [17:0] in_s_i,
  input  cmd_e               cmd_i,
  input  logic [Aw-1:0]      vidx_i,
  output dp_status_t         status_o,
  output logic               out_ok_o,
  output logic [31:0]        out_dist_o,
  output logic signed [31:0] out_min_x_o,
  output logic signed [31:0] out_max_x_o,
  output logic signed [31:0] out_min_y_o,
  output logic signed [31:0] out_max_y_o
);

  logic signed [31:0] mem_x [MaxVertices];
  logic signed [31:0] mem_y [MaxVertices];

  logic [6:0]         count_q;
  logic [Nw-1:0]      n_eff;
  logic [2:0]         op_q;
  logic [5:0]         idx_q;
  logic signed [31:0] cx_q, cy_q, f_q;
  logic signed [17:0] c_q, s_q;
  logic               idx_ok;

  logic signed [31:0] rdx_q, rdy_q, vx_q, vy_q, tx_q, ty_q;
  logic signed [31:0] ax_q, ay_q, bx_q, by_q;
  logic signed [32:0] ex_q, ey_q, wx_q, wy_q, fx_q, fy_q;
  logic signed [32:0] mag_ex, mag_ey;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic signed [66:0] acc_q, len2_q, dot_q, sum;
  logic [66:0]        r_q, r2;
  logic [31:0]        q_q;
  logic [65:0]        best_q;
  logic [63:0]        sv_q;
  logic [34:0]        rem_q, rem2;
  logic [33:0]        trial;
  logic [31:0]        root_q;
  logic signed [31:0] mnx_q, mxx_q, mny_q, mxy_q;
  logic [65:0]        rnd_off;
  logic signed [32:0] off_o;
  logic               off_neg;
  logic [Aw-1:0]      raddr;
  logic               first;

  always_comb begin
    if (count_q < 7'd2) begin
      n_eff = Nw'(2);
    end else if (32'(count_q) > 32'(MaxVertices)) begin
      n_eff = Nw'(MaxVertices);
    end else begin
      n_eff = Nw'(count_q);
    end
  end

  assign idx_ok = 32'(idx_q) < 32'(n_eff);
  assign first  = (vidx_i == '0);

  assign status_o.dot_le0    = (dot_q <= 67'sd0);
  assign status_o.dot_ge_len = (dot_q >= len2_q);
  assign status_o.last_vtx   = (32'(vidx_i) + 32'd1 == 32'(n_eff));
  assign status_o.last_seg   = (32'(vidx_i) + 32'd2 == 32'(n_eff));

  assign mag_ex = ex_q[32] ? -ex_q : ex_q;
  assign mag_ey = ey_q[32] ? -ey_q : ey_q;

  always_comb begin
    case (cmd_i)
      CMD_SC_M1: begin mul_a = 33'(vx_q); mul_b = 33'(f_q); end
      CMD_SC_M2: begin mul_a = 33'(vy_q); mul_b = 33'(f_q); end
      CMD_RT_M1: begin mul_a = 33'(vx_q); mul_b = 33'(c_q); end
      CMD_RT_M2: begin mul_a = 33'(vy_q); mul_b = 33'(s_q); end
      CMD_RT_M3: begin mul_a = 33'(vx_q); mul_b = 33'(s_q); end
      CMD_RT_M4: begin mul_a = 33'(vy_q); mul_b = 33'(c_q); end
      CMD_D_M1:  begin mul_a = ex_q; mul_b = ex_q; end
      CMD_D_M2:  begin mul_a = ey_q; mul_b = ey_q; end
      CMD_D_M3:  begin mul_a = wx_q; mul_b = ex_q; end
      CMD_D_M4:  begin mul_a = wy_q; mul_b = ey_q; end
      CMD_OFF1:  begin mul_a = $signed({1'b0, q_q}); mul_b = mag_ex; end
      CMD_OFF2:  begin mul_a = $signed({1'b0, q_q}); mul_b = mag_ey; end
      CMD_S1:    begin mul_a = fx_q; mul_b = fx_q; end
      CMD_S2:    begin mul_a = fy_q; mul_b = fy_q; end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign sum     = acc_q + 67'(prod_q);
  assign r2      = {r_q[65:0], 1'b0};
  assign rem2    = {rem_q[32:0], sv_q[63:62]};
  assign trial   = {root_q, 2'b01};
  assign rnd_off = prod_q + 66'sd2147483648;
  assign off_neg = (cmd_i == CMD_OFF2) ? ex_q[32] : ey_q[32];
  assign off_o   = off_neg ? -$signed({1'b0, rnd_off[63:32]})
                           : $signed({1'b0, rnd_off[63:32]});
  assign raddr   = (cmd_i == CMD_RDB_CAPA) ? vidx_i + 1'b1 : vidx_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 7'd2;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_WRITE && idx_ok) begin
      mem_x[Aw'(idx_q)] <= cx_q;
      mem_y[Aw'(idx_q)] <= cy_q;
    end else if (cmd_i == CMD_XF_WR) begin
      if (op_q == OP_TRANSLATE) begin
        mem_x[vidx_i] <= sat32(67'(vx_q) + 67'(cx_q));
        mem_y[vidx_i] <= sat32(67'(vy_q) + 67'(cy_q));
      end else begin
        mem_x[vidx_i] <= tx_q;
        mem_y[vidx_i] <= ty_q;
      end
    end
    if (cmd_i == CMD_RD_I || cmd_i == CMD_RDB_CAPA) begin
      rdx_q <= mem_x[raddr];
      rdy_q <= mem_y[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_fire_i) begin
      op_q  <= in_op_i;
      idx_q <= in_idx_i;
      cx_q  <= in_cx_i;
      cy_q  <= in_cy_i;
      f_q   <= in_f_i;
      c_q   <= in_c_i;
      s_q   <= in_s_i;
    end
    case (cmd_i)
      CMD_CAP_V: begin
        vx_q <= rdx_q;
        vy_q <= rdy_q;
        if (op_q == OP_BOX) begin
          if (first || rdx_q < mnx_q) mnx_q <= rdx_q;
          if (first || rdx_q > mxx_q) mxx_q <= rdx_q;
          if (first || rdy_q < mny_q) mny_q <= rdy_q;
          if (first || rdy_q > mxy_q) mxy_q <= rdy_q;
        end
      end
      CMD_SC_M2:    tx_q <= rnd_sat(67'(prod_q), CoordFracBits);
      CMD_SC_M3:    ty_q <= rnd_sat(67'(prod_q), CoordFracBits);
      CMD_RT_M2:    acc_q <= 67'(prod_q);
      CMD_RT_M3:    tx_q <= rnd_sat(acc_q - 67'(prod_q), TrigFracBits);
      CMD_RT_M4:    acc_q <= 67'(prod_q);
      CMD_RT_M5:    ty_q <= rnd_sat(sum, TrigFracBits);
      CMD_RDB_CAPA: begin ax_q <= rdx_q; ay_q <= rdy_q; end
      CMD_CAP_B:    begin bx_q <= rdx_q; by_q <= rdy_q; end
      CMD_SETUP: begin
        ex_q <= 33'(bx_q) - 33'(ax_q);
        ey_q <= 33'(by_q) - 33'(ay_q);
        wx_q <= 33'(cx_q) - 33'(ax_q);
        wy_q <= 33'(cy_q) - 33'(ay_q);
      end
      CMD_D_M2: acc_q  <= 67'(prod_q);
      CMD_D_M3: len2_q <= sum;
      CMD_D_M4: acc_q  <= 67'(prod_q);
      CMD_D_M5: dot_q  <= sum;
      CMD_DEC: begin
        r_q <= dot_q;
        q_q <= '0;
        if (dot_q <= 67'sd0) begin
          fx_q <= wx_q;
          fy_q <= wy_q;
        end else begin
          fx_q <= wx_q - ex_q;
          fy_q <= wy_q - ey_q;
        end
      end
      CMD_DIV: begin
        if (r2 >= len2_q) begin
          r_q <= r2 - len2_q;
          q_q <= {q_q[30:0], 1'b1};
        end else begin
          r_q <= r2;
          q_q <= {q_q[30:0], 1'b0};
        end
      end
      CMD_OFF2: fx_q  <= wx_q - off_o;
      CMD_OFF3: fy_q  <= wy_q - off_o;
      CMD_S2:   acc_q <= 67'(prod_q);
      CMD_S3: begin
        if (first || sum[65:0] < best_q) best_q <= sum[65:0];
      end
      CMD_SQ_INIT: begin
        sv_q   <= best_q[63:0];
        rem_q  <= '0;
        root_q <= '0;
      end
      CMD_SQ: begin
        sv_q <= {sv_q[61:0], 2'b00};
        if (rem2 >= 35'(trial)) begin
          rem_q  <= rem2 - 35'(trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem2;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      CMD_FIN: begin
        out_ok_o    <= (op_q <= OP_BOX) && (op_q != OP_WRITE || idx_ok);
        out_dist_o  <= (op_q != OP_DISTANCE) ? 32'd0 :
                       (best_q[65:64] != 2'b00) ? 32'hffffffff : root_q;
        out_min_x_o <= (op_q == OP_BOX) ? mnx_q : 32'sd0;
        out_max_x_o <= (op_q == OP_BOX) ? mxx_q : 32'sd0;
        out_min_y_o <= (op_q == OP_BOX) ? mny_q : 32'sd0;
        out_max_y_o <= (op_q == OP_BOX) ? mxy_q : 32'sd0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/polyline_vertex_geometry_engine_top.sv =====
// Top level of the polyline vertex geometry engine.
// Joins the sequencer and the datapath. Depends on pvge_pkg, pvge_ctrl, pvge_dp.
//
// Usage:
//   s_axis carries one command beat: tuser is the op, tdata the operands.
//   m_axis returns one result beat per command: tuser is ok, tdata the values.
//   cfg writes vertex_count (cfg_ready_o is always high); write it only while idle.
// Work from the accepting edge to the result beat, one command at a time:
//   write stores one vertex; translate, scale and rotate read, transform
//   and write back each vertex in turn; bounding box reads each vertex;
//   distance sets up each segment, with the 32-step restoring divider
//   only when the projection falls inside the segment, then runs the 32-step
//   square root. Every command ends by registering the result.
//   The next beat can be taken in the cycle after the result is registered.
//   The worst case is a long distance command, dominated by the divider loop.
// Reset clears the sequencer and sets vertex_count to 2; vertex memory is
// not cleared and holds garbage until written.
// A stalled receiver holds the result in the output register; a new command
// is still accepted and runs, and its result waits until the old beat is taken.
module polyline_vertex_geometry_engine_top import pvge_pkg::*; #(
  parameter int MaxVertices   = MaxVerticesDef,
  parameter int CoordFracBits = CoordFracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic [6:0]   cfg_data_i,
  output logic         cfg_ready_o,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_index, coord_x, coord_y, scale_factor, cosine, sine, zero pad
  input  logic [143:0] s_axis_tdata,
  // op
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance, min_x, max_x, min_y, max_y
  output logic [159:0] m_axis_tdata,
  // ok
  output logic         m_axis_tuser
);

  localparam int Aw = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;

  cmd_e               cmd;
  dp_status_t         status;
  logic [Aw-1:0]      vidx;
  logic               in_fire;
  logic [31:0]        distance;
  logic signed [31:0] mnx, mxx, mny, mxy;

  assign cfg_ready_o  = 1'b1;
  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = {mxy, mny, mxx, mnx, distance};

  pvge_ctrl #(.MaxVertices(MaxVertices)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd),
    .vidx_o     (vidx)
  );

  pvge_dp #(.MaxVertices(MaxVertices), .CoordFracBits(CoordFracBits)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_fire_i  (in_fire),
    .in_op_i    (s_axis_tuser),
    .in_idx_i   (s_axis_tdata[5:0]),
    .in_cx_i    (s_axis_tdata[37:6]),
    .in_cy_i    (s_axis_tdata[69:38]),
    .in_f_i     (s_axis_tdata[101:70]),
    .in_c_i     (s_axis_tdata[119:102]),
    .in_s_i     (s_axis_tdata[137:120]),
    .cmd_i      (cmd),
    .vidx_i     (vidx),
    .status_o   (status),
    .out_ok_o   (m_axis_tuser),
    .out_dist_o (distance),
    .out_min_x_o(mnx),
    .out_max_x_o(mxx),
    .out_min_y_o(mny),
    .out_max_y_o(mxy)
  );

endmodule

// ===== hw/rtl/pvge_checker.sv =====
// Port-level checks for the polyline vertex geometry engine.
// Bound to polyline_vertex_geometry_engine_top; no package dependency.
module pvge_port_props (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed under stall");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while busy");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 160'd0)
    else $error("rejected command returned nonzero data");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[63:32]) <= $signed(m_axis_tdata[95:64])
                   && $signed(m_axis_tdata[127:96]) <= $signed(m_axis_tdata[159:128]))
    else $error("bounding box min above max");

endmodule

bind polyline_vertex_geometry_engine_top pvge_port_props u_pvge_port_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
